[sv/jhse_pkg.sv]
`default_nettype none

package jhse_pkg;

    // Operation carried in the low bits of s_tuser
    typedef enum logic [1:0] {
        OP_LOAD_DC = 2'd0,
        OP_LOAD_AC = 2'd1,
        OP_ENC_DC  = 2'd2,
        OP_ENC_AC  = 2'd3
    } op_t;

    // Field widths
    localparam int IDX_W    = 8;
    localparam int CODE_W   = 16;
    localparam int LEN_W    = 5;
    localparam int RUN_W    = 4;
    localparam int SIZE_W   = 4;
    localparam int AMP_W    = 16;
    localparam int MAG_W    = AMP_W + 1;
    localparam int EXTRA_W  = 15;
    localparam int CAT_W    = 5;
    localparam int BITS_W   = 31;
    localparam int COUNT_W  = 5;

    // Channel widths
    localparam int SDATA_W  = 56;
    localparam int SUSER_W  = 3;
    localparam int MDATA_W  = 40;
    localparam int MUSER_W  = 1;

    // Table geometry
    localparam int DC_ENTRIES      = 16;
    localparam int AC_ENTRIES      = 256;
    localparam int MAX_DC_CATEGORY = 12;

endpackage : jhse_pkg

`default_nettype wire

[sv/jpeg_huffman_symbol_encoder_top.sv]
// Channel | Dir | tdata (low bit up)                                   | tuser
// s_      | in  | entry_index, entry_code, entry_length, run_length,   | operation,
//         |     | code_size, amplitude                                 | table_select
// m_      | out | code_bits, bit_count                                 | category_error
//
// One beat per cycle sustained while m_tready holds; after the input register an encode beat
// passes stage B, stage C, then the output register to m_; loads give none.
// The table memories are read and written in the second stage, in beat order, so
// an encode straight after a load of the same entry sees the new entry.
// aresetn (synchronous) clears all valid bits; table contents stay undefined until loaded.
// Each stage stalls only when occupied and the stage after it is full and stalled.
`default_nettype none

module jpeg_huffman_symbol_encoder_top
    import jhse_pkg::*;
#(
    parameter int TABLE_SETS      = 2,
    parameter int MAX_CODE_LENGTH = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // entry_index[7:0], entry_code[23:8], entry_length[28:24], run_length[32:29],
    // code_size[36:33], amplitude[52:37], zero fill[55:53]
    input  wire logic [SDATA_W-1:0] s_tdata,
    // operation[1:0], table_select[2]
    input  wire logic [SUSER_W-1:0] s_tuser,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // code_bits[30:0], bit_count[35:31], zero fill[39:36]
    output logic [MDATA_W-1:0]      m_tdata,
    // category_error[0]
    output logic [MUSER_W-1:0]      m_tuser
);

    localparam int SET_W   = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
    localparam int DC_AW   = $clog2(TABLE_SETS * DC_ENTRIES);
    localparam int AC_AW   = $clog2(TABLE_SETS * AC_ENTRIES);
    localparam int ENTRY_W = LEN_W + MAX_CODE_LENGTH;

    // ------------------------------------------------------------------
    // Handshake chain
    // ------------------------------------------------------------------
    logic a_valid_reg, b_valid_reg, c_valid_reg, m_tvalid_reg;
    logic ready_a, ready_b, ready_c, ready_d;
    logic adv_c;

    assign ready_d  = !m_tvalid_reg || m_tready;
    assign ready_c  = !c_valid_reg || ready_d;
    assign ready_b  = !b_valid_reg || ready_c;
    assign ready_a  = !a_valid_reg || ready_b;
    assign adv_c    = b_valid_reg && ready_c;
    assign s_tready = ready_a;

    // ------------------------------------------------------------------
    // Stage A: input register
    // ------------------------------------------------------------------
    op_t                a_op_reg;
    logic               a_sel_reg;
    logic [IDX_W-1:0]   a_idx_reg;
    logic [CODE_W-1:0]  a_code_reg;
    logic [LEN_W-1:0]   a_len_reg;
    logic [RUN_W-1:0]   a_run_reg;
    logic [SIZE_W-1:0]  a_size_reg;
    logic [AMP_W-1:0]   a_amp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (ready_a) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_a) begin
            a_op_reg   <= op_t'(s_tuser[1:0]);
            a_sel_reg  <= s_tuser[2];
            a_idx_reg  <= s_tdata[7:0];
            a_code_reg <= s_tdata[23:8];
            a_len_reg  <= s_tdata[28:24];
            a_run_reg  <= s_tdata[32:29];
            a_size_reg <= s_tdata[36:33];
            a_amp_reg  <= s_tdata[52:37];
        end
    end

    // Stage A logic: magnitude, sign, table set and entry packing
    logic [MAG_W-1:0]           amp_ext;
    logic [MAG_W-1:0]           mag_next;
    logic                       neg_next;
    logic [SET_W-1:0]           set_next;
    logic [LEN_W-1:0]           len_sat;
    logic [MAX_CODE_LENGTH:0]   code_mask;
    logic [ENTRY_W-1:0]         entry_next;

    always_comb begin
        amp_ext  = {a_amp_reg[AMP_W-1], a_amp_reg};
        neg_next = a_amp_reg[AMP_W-1];
        mag_next = neg_next ? MAG_W'(~amp_ext + MAG_W'(1)) : amp_ext;

        // Clamp an out-of-range selector to the last table set
        set_next = (32'(a_sel_reg) >= TABLE_SETS) ? SET_W'(TABLE_SETS - 1)
                                                  : SET_W'(a_sel_reg);

        // Saturate the length and drop code bits above it
        len_sat   = (a_len_reg > LEN_W'(MAX_CODE_LENGTH)) ? LEN_W'(MAX_CODE_LENGTH)
                                                          : a_len_reg;
        code_mask = ~({(MAX_CODE_LENGTH + 1){1'b1}} << len_sat);
        entry_next = {len_sat,
                      a_code_reg[MAX_CODE_LENGTH-1:0] & code_mask[MAX_CODE_LENGTH-1:0]};
    end

    // ------------------------------------------------------------------
    // Stage B register
    // ------------------------------------------------------------------
    op_t                b_op_reg;
    logic [SET_W-1:0]   b_set_reg;
    logic [IDX_W-1:0]   b_idx_reg;
    logic [ENTRY_W-1:0] b_entry_reg;
    logic [RUN_W-1:0]   b_run_reg;
    logic [SIZE_W-1:0]  b_size_reg;
    logic [MAG_W-1:0]   b_mag_reg;
    logic               b_neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (ready_b) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_b) begin
            b_op_reg    <= a_op_reg;
            b_set_reg   <= set_next;
            b_idx_reg   <= a_idx_reg;
            b_entry_reg <= entry_next;
            b_run_reg   <= a_run_reg;
            b_size_reg  <= a_size_reg;
            b_mag_reg   <= mag_next;
            b_neg_reg   <= neg_next;
        end
    end

    // Stage B logic: category, amplitude bits and table addresses
    logic [CAT_W-1:0]   cat;
    logic               b_is_dc;
    logic               b_is_enc;
    logic               err_next;
    logic [SIZE_W-1:0]  nextra_next;
    logic [EXTRA_W-1:0] amp_raw;
    logic [EXTRA_W-1:0] extra_mask;
    logic [EXTRA_W-1:0] extra_next;
    logic [DC_AW-1:0]   dc_wr_addr, dc_rd_addr;
    logic [AC_AW-1:0]   ac_wr_addr, ac_rd_addr;

    always_comb begin
        // Highest set magnitude bit gives the category
        cat = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (b_mag_reg[i]) begin
                cat = CAT_W'(i + 1);
            end
        end

        b_is_dc  = (b_op_reg == OP_ENC_DC);
        b_is_enc = (b_op_reg == OP_ENC_DC) || (b_op_reg == OP_ENC_AC);
        err_next = b_is_dc && (cat > CAT_W'(MAX_DC_CATEGORY));

        nextra_next = b_is_dc ? cat[SIZE_W-1:0] : b_size_reg;
        amp_raw     = b_neg_reg ? ~b_mag_reg[EXTRA_W-1:0] : b_mag_reg[EXTRA_W-1:0];
        extra_mask  = ~({EXTRA_W{1'b1}} << nextra_next);
        extra_next  = amp_raw & extra_mask;

        dc_wr_addr = DC_AW'({b_set_reg, b_idx_reg[SIZE_W-1:0]});
        dc_rd_addr = DC_AW'({b_set_reg, cat[SIZE_W-1:0]});
        ac_wr_addr = AC_AW'({b_set_reg, b_idx_reg});
        ac_rd_addr = AC_AW'({b_set_reg, b_run_reg, b_size_reg});
    end

    // ------------------------------------------------------------------
    // Table memories: written and read as a beat leaves stage B
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] dc_mem [TABLE_SETS*DC_ENTRIES];
    logic [ENTRY_W-1:0] ac_mem [TABLE_SETS*AC_ENTRIES];
    logic [ENTRY_W-1:0] dc_rd_reg;
    logic [ENTRY_W-1:0] ac_rd_reg;

    always_ff @(posedge aclk) begin
        if (adv_c) begin
            // Drop DC loads beyond the sixteen category entries
            if (b_op_reg == OP_LOAD_DC && b_idx_reg[IDX_W-1:SIZE_W] == '0) begin
                dc_mem[dc_wr_addr] <= b_entry_reg;
            end
            dc_rd_reg <= dc_mem[dc_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_c) begin
            if (b_op_reg == OP_LOAD_AC) begin
                ac_mem[ac_wr_addr] <= b_entry_reg;
            end
            ac_rd_reg <= ac_mem[ac_rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Stage C register: loads leave the pipeline here
    // ------------------------------------------------------------------
    logic               c_is_dc_reg;
    logic               c_err_reg;
    logic [SIZE_W-1:0]  c_nextra_reg;
    logic [EXTRA_W-1:0] c_extra_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (ready_c) begin
            c_valid_reg <= b_valid_reg && b_is_enc;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_c) begin
            c_is_dc_reg  <= b_is_dc;
            c_err_reg    <= err_next;
            c_nextra_reg <= nextra_next;
            c_extra_reg  <= extra_next;
        end
    end

    // Stage C logic: join code and amplitude bits
    logic [ENTRY_W-1:0] c_entry;
    logic [BITS_W-1:0]  bits_next;
    logic [COUNT_W-1:0] count_next;

    always_comb begin
        c_entry = c_is_dc_reg ? dc_rd_reg : ac_rd_reg;
        if (c_err_reg) begin
            bits_next  = '0;
            count_next = '0;
        end else begin
            bits_next  = (BITS_W'(c_entry[MAX_CODE_LENGTH-1:0]) << c_nextra_reg)
                       | BITS_W'(c_extra_reg);
            count_next = COUNT_W'(c_entry[ENTRY_W-1 -: LEN_W] + LEN_W'(c_nextra_reg));
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [MDATA_W-1:0] m_tdata_reg;
    logic [MUSER_W-1:0] m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ready_d) begin
            m_tvalid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_d) begin
            m_tdata_reg <= MDATA_W'({count_next, bits_next});
            m_tuser_reg <= MUSER_W'(c_err_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    // A category error carries no bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("error beat carries non-zero data");

    // Input back-pressure only when the first stage is occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> a_valid_reg)
        else $error("input stalled with empty first stage");

    // A stalled stage C beat keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && !ready_d |=> c_valid_reg && $stable(c_extra_reg)
                                    && $stable(c_nextra_reg))
        else $error("stage C beat changed while stalled");

    // Reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
`endif

endmodule : jpeg_huffman_symbol_encoder_top

`default_nettype wire
